/* hdl/maf_pkg.sv */
// ----------------------------------------------------------------------------
// maf_pkg: shared constants for the moving average filter
// Register width and reset value of the window length register.
// ----------------------------------------------------------------------------
package maf_pkg;

  // width of the window length register as seen on the config port
  localparam int CFG_BITS = 7;

  // window length after reset
  localparam int WINDOW_RESET = 3;

endpackage

/* hdl/maf_div.sv */
// ----------------------------------------------------------------------------
// maf_div: serial signed divider
// Restoring division of a signed sum by an unsigned window length, one
// quotient bit per cycle, truncated toward zero.
// ----------------------------------------------------------------------------
module maf_div #(
  parameter int SUM_BITS    = 22,
  parameter int DIV_BITS    = 7,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [SUM_BITS-1:0]    dividend,
  input  logic [DIV_BITS-1:0]    divisor,
  output logic                   done,
  output logic [SAMPLE_BITS-1:0] quotient
);

  localparam int STEP_BITS = (SUM_BITS > 1) ? $clog2(SUM_BITS) : 1;

  typedef enum logic [1:0] {
    D_IDLE,
    D_RUN,
    D_FIX
  } div_state_t;

  div_state_t           state;
  logic [STEP_BITS-1:0] step;
  logic [DIV_BITS-1:0]  rem;
  logic [DIV_BITS-1:0]  den;
  logic [SUM_BITS-1:0]  quo;
  logic                 neg;

  logic [DIV_BITS:0]    rem_shift;
  logic                 fits;
  logic [DIV_BITS-1:0]  rem_next;

  // one restoring step: bring down the next dividend bit and try to subtract
  always_comb begin
    rem_shift = {rem, quo[SUM_BITS-1]};
    fits      = (rem_shift >= {1'b0, den});
    if (fits) begin
      rem_next = DIV_BITS'(rem_shift - {1'b0, den});
    end else begin
      rem_next = rem_shift[DIV_BITS-1:0];
    end
  end

  // sequencer, shift registers and registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        D_IDLE: begin
          if (start) begin
            neg   <= dividend[SUM_BITS-1];
            quo   <= dividend[SUM_BITS-1] ? (~dividend + 1'b1) : dividend;
            den   <= divisor;
            rem   <= '0;
            step  <= '0;
            state <= D_RUN;
          end
        end
        D_RUN: begin
          rem  <= rem_next;
          quo  <= {quo[SUM_BITS-2:0], fits};
          step <= step + 1'b1;
          if (step == STEP_BITS'(SUM_BITS - 1)) begin
            state <= D_FIX;
          end
        end
        D_FIX: begin
          // restore the sign; magnitude always fits the sample range
          quotient <= neg ? SAMPLE_BITS'(~quo + 1'b1) : SAMPLE_BITS'(quo);
          done     <= 1'b1;
          state    <= D_IDLE;
        end
        default: begin
          state <= D_IDLE;
        end
      endcase
    end
  end

endmodule

/* hdl/moving_average_filter.sv */
// ----------------------------------------------------------------------------
// moving_average_filter: boxcar moving average over a sample stream
// Ring of recent samples in a synchronous memory, running sum, serial divide.
// ----------------------------------------------------------------------------
// One sample word is taken at a time. A sample that completes or extends a
// full window passes from accept through the ring read, the sum update and
// ring write, and the serial divider, which produces one quotient bit per
// cycle, to the result word; a sample that gives no result goes only through
// the ring read, then the sum update and ring write. A finished result waits
// in the output register while the next sample word is accepted. The window
// length register is written through the config channel while the block is
// idle; each write restarts the series. A zero length acts as one and a
// length above WINDOW_MAX acts as WINDOW_MAX.
module moving_average_filter #(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // sample channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          last_of_series,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] average,
  // config channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [maf_pkg::CFG_BITS-1:0]  window_length
);

  localparam int PTR_BITS = $clog2(WINDOW_MAX);
  localparam int CNT_BITS = $clog2(WINDOW_MAX + 1);
  localparam int SUM_BITS = SAMPLE_BITS + PTR_BITS;
  localparam int WIN_INIT = (maf_pkg::WINDOW_RESET > WINDOW_MAX) ?
                            WINDOW_MAX : maf_pkg::WINDOW_RESET;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_DIV
  } state_t;

  state_t                         state;
  logic [CNT_BITS-1:0]            win;
  logic [CNT_BITS-1:0]            fill;
  logic [PTR_BITS-1:0]            pos;
  logic signed [SUM_BITS-1:0]     sum;
  logic signed [SAMPLE_BITS-1:0]  samp;
  logic                           last;
  logic signed [SAMPLE_BITS-1:0]  oldest;

  logic signed [SAMPLE_BITS-1:0]  ring [WINDOW_MAX];

  logic                           full;
  logic [CNT_BITS-1:0]            fill_next;
  logic [PTR_BITS-1:0]            pos_next;
  logic signed [SUM_BITS-1:0]     sum_next;
  logic                           emit;
  logic [31:0]                    cfg_wide;
  logic [CNT_BITS-1:0]            win_cfg;
  logic                           div_start;
  logic                           div_done;
  logic [SAMPLE_BITS-1:0]         div_quo;
  logic                           out_free;
  logic                           div_done_seen;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign out_free  = !out_valid || out_ready;

  // clamp the written length to 1..WINDOW_MAX
  always_comb begin
    cfg_wide = 32'(window_length);
    if (cfg_wide == 32'd0) begin
      win_cfg = CNT_BITS'(1);
    end else if (cfg_wide > 32'(WINDOW_MAX)) begin
      win_cfg = CNT_BITS'(WINDOW_MAX);
    end else begin
      win_cfg = CNT_BITS'(cfg_wide);
    end
  end

  // sum, fill and position update for the word in hand
  always_comb begin
    full = (fill >= win);
    if (full) begin
      sum_next  = sum + {{PTR_BITS{samp[SAMPLE_BITS-1]}}, samp}
                      - {{PTR_BITS{oldest[SAMPLE_BITS-1]}}, oldest};
      fill_next = fill;
    end else begin
      sum_next  = sum + {{PTR_BITS{samp[SAMPLE_BITS-1]}}, samp};
      fill_next = fill + 1'b1;
    end
    emit = (fill_next >= win);
    if ((CNT_BITS'(pos) + 1'b1) == win) begin
      pos_next = '0;
    end else begin
      pos_next = pos + 1'b1;
    end
  end

  assign div_start = (state == S_CALC) && emit;

  // sample ring: read at accept, written back during the update cycle
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      oldest <= ring[pos];
    end
    if (state == S_CALC) begin
      ring[pos] <= samp;
    end
  end

  // control, series state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      win       <= CNT_BITS'(WIN_INIT);
      fill      <= '0;
      pos       <= '0;
      sum       <= '0;
      out_valid <= 1'b0;
    end else begin
      // output register: load a finished quotient, else drop an accepted word
      if ((state == S_DIV) && div_done_seen && out_free) begin
        average   <= div_quo;
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            samp  <= sample;
            last  <= last_of_series;
            state <= S_CALC;
          end
        end
        S_CALC: begin
          if (last) begin
            sum  <= '0;
            fill <= '0;
            pos  <= '0;
          end else begin
            sum  <= sum_next;
            fill <= fill_next;
            pos  <= pos_next;
          end
          state <= emit ? S_DIV : S_IDLE;
        end
        S_DIV: begin
          // the divider holds its quotient until the output slot frees up
          if (div_done_seen && out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      // a length write restarts the series
      if (cfg_valid && cfg_ready) begin
        win  <= win_cfg;
        sum  <= '0;
        fill <= '0;
        pos  <= '0;
      end
    end
  end

  // remembers that the divider finished for the word in hand
  always_ff @(posedge clk) begin
    if (rst) begin
      div_done_seen <= 1'b0;
    end else if (state != S_DIV) begin
      div_done_seen <= 1'b0;
    end else if (div_done) begin
      div_done_seen <= 1'b1;
    end
  end

  maf_div #(
    .SUM_BITS    (SUM_BITS),
    .DIV_BITS    (CNT_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_next),
    .divisor  (win),
    .done     (div_done),
    .quotient (div_quo)
  );

endmodule

/* hdl/maf_chk.sv */
// ----------------------------------------------------------------------------
// maf_chk: port checker for the moving average filter
// Watches the top level ports and flags ordering and handshake slips.
// ----------------------------------------------------------------------------
module maf_chk #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [SAMPLE_BITS-1:0]       average,
  input logic                         cfg_valid,
  input logic                         cfg_ready
);

  logic in_acc;

  assign in_acc = in_valid && in_ready;

  // after reset the block is empty and ready for a sample word
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && in_ready))
    else $error("block not empty and ready after reset");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(average)))
    else $error("result word dropped or changed while stalled");

  // one sample word in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !in_ready)
    else $error("second sample word taken while one is in work");

  // a result never appears in the cycle right after an accept
  a_no_instant_out: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !$rose(out_valid))
    else $error("result word appeared without the divide");

  // a length write is only taken while no sample word is in work
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |-> in_ready)
    else $error("length word taken while a sample word is in work");

endmodule

bind moving_average_filter maf_chk #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_maf_chk (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .average        (average),
  .cfg_valid      (cfg_valid),
  .cfg_ready      (cfg_ready)
);
